@@ rtl/core/nps_pkg.sv @@
package nps_pkg;

    localparam int DEF_MAX_POINTS  = 256;
    localparam int DEF_COORD_BITS  = 16;

    localparam int POS_W     = 16;
    localparam int IDX_OUT_W = 8;
    localparam int DIST_W    = 33;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/nps_ctrl.sv @@
module nps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_cmd,
    input  nps_pkg::t_dp_stat i_stat,
    output nps_pkg::t_dp_cmd  o_cmd,
    output logic              o_stall
);

    nps_pkg::t_state r_state;
    nps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.scan_en  = 1'b0;
        o_cmd.load_out = 1'b0;
        o_stall        = 1'b1;
        unique case (r_state)
            nps_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_cmd == nps_pkg::CMD_QUERY && !i_stat.count_zero) begin
                        n_state = nps_pkg::ST_SCAN;
                    end else begin
                        n_state = nps_pkg::ST_DONE;
                    end
                end
            end
            nps_pkg::ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = nps_pkg::ST_DONE;
                end
            end
            nps_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = nps_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ rtl/core/nps_dp.sv @@
module nps_dp #(
    parameter int MAX_POINTS = nps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_cmd,
    input  logic [nps_pkg::POS_W-1:0]    i_pos_x,
    input  logic [nps_pkg::POS_W-1:0]    i_pos_y,
    input  logic                         i_stall,
    input  nps_pkg::t_dp_cmd             i_ctl,
    output nps_pkg::t_dp_stat            o_stat,
    output logic                         o_valid,
    output logic [nps_pkg::IDX_OUT_W-1:0] o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]   o_nearest_dist_sq,
    output logic                         o_found,
    output logic                         o_table_full
);

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int CB      = COORD_BITS;
    localparam int IN_EXT_W = (CB > nps_pkg::POS_W) ? CB : nps_pkg::POS_W;
    localparam int SQ_W    = 2 * CB;
    localparam int EXT_W   = (SQ_W + 1 > nps_pkg::DIST_W) ? SQ_W + 1 : nps_pkg::DIST_W;
    localparam int IOUT_W  = (IDX_W > nps_pkg::IDX_OUT_W) ? IDX_W : nps_pkg::IDX_OUT_W;

    logic [CB-1:0] mem_x [MAX_POINTS];
    logic [CB-1:0] mem_y [MAX_POINTS];

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_addr;
    logic             r_v0, r_v1, r_v2;
    logic             r_first;
    logic             r_out_valid;

    logic [CB-1:0]    r_qx, r_qy;
    logic [CB-1:0]    r_rd_x, r_rd_y;
    logic [IDX_W-1:0] r_idx0, r_idx1, r_idx2;
    logic [CB-1:0]    r_mag_x, r_mag_y;
    logic [SQ_W-1:0]  r_sq_x, r_sq_y;
    logic [nps_pkg::DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0] r_best_idx;
    logic             r_found;
    logic             r_res_full;
    logic [nps_pkg::IDX_OUT_W-1:0] r_res_idx;

    logic [nps_pkg::IDX_OUT_W-1:0] r_out_idx;
    logic [nps_pkg::DIST_W-1:0]    r_out_dist;
    logic                          r_out_found;
    logic                          r_out_full;

    logic [IN_EXT_W-1:0] in_x_ext, in_y_ext;
    logic [CB-1:0]       in_x, in_y;
    logic                tbl_full;
    logic                is_insert, is_clear, is_query;
    logic                wr_en;
    logic signed [CB:0]  dx, dy;
    logic signed [CB:0]  ax, ay;
    logic [EXT_W-1:0]    sum_ext;
    logic [nps_pkg::DIST_W-1:0] dist_sat;
    logic                better;
    logic [IOUT_W-1:0]   cnt_idx_ext, best_idx_ext;

    // low COORD_BITS of the field, zero extended when the field is narrower
    assign in_x_ext = IN_EXT_W'(i_pos_x);
    assign in_y_ext = IN_EXT_W'(i_pos_y);
    assign in_x     = in_x_ext[CB-1:0];
    assign in_y     = in_y_ext[CB-1:0];

    assign is_clear  = (i_cmd == nps_pkg::CMD_CLEAR);
    assign is_insert = (i_cmd == nps_pkg::CMD_INSERT);
    assign is_query  = (i_cmd == nps_pkg::CMD_QUERY);
    assign tbl_full  = (r_count == CNT_W'(MAX_POINTS));
    assign wr_en     = i_ctl.accept && is_insert && !tbl_full;

    assign cnt_idx_ext  = IOUT_W'(r_count[IDX_W-1:0]);
    assign best_idx_ext = IOUT_W'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[IDX_W-1:0]] <= in_x;
            mem_y[r_count[IDX_W-1:0]] <= in_y;
        end
        if (i_ctl.scan_en) begin
            r_rd_x <= mem_x[r_addr];
            r_rd_y <= mem_y[r_addr];
        end
    end

    // stage 1: coordinate differences, magnitude only
    always_comb begin
        dx = $signed({r_rd_x[CB-1], r_rd_x}) - $signed({r_qx[CB-1], r_qx});
        dy = $signed({r_rd_y[CB-1], r_rd_y}) - $signed({r_qy[CB-1], r_qy});
        ax = dx[CB] ? -dx : dx;
        ay = dy[CB] ? -dy : dy;
    end

    // stage 3: sum, saturate, compare with best so far
    always_comb begin
        sum_ext  = EXT_W'(r_sq_x) + EXT_W'(r_sq_y);
        dist_sat = (sum_ext > EXT_W'(nps_pkg::DIST_MAX)) ? nps_pkg::DIST_MAX
                                                          : sum_ext[nps_pkg::DIST_W-1:0];
        better   = r_first || (dist_sat < r_best_dist);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v0 <= i_ctl.scan_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_ctl.accept) begin
                r_addr  <= '0;
                r_first <= 1'b1;
                if (is_clear) begin
                    r_count <= '0;
                end else if (wr_en) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else begin
                if (i_ctl.scan_en) begin
                    r_addr <= r_addr + IDX_W'(1);
                end
                if (r_v2) begin
                    r_first <= 1'b0;
                end
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_qx       <= in_x;
            r_qy       <= in_y;
            r_found    <= is_query && (r_count != '0);
            r_res_full <= is_insert && tbl_full;
            r_res_idx  <= wr_en ? cnt_idx_ext[nps_pkg::IDX_OUT_W-1:0] : '0;
        end
        if (i_ctl.scan_en) begin
            r_idx0 <= r_addr;
        end
        r_idx1  <= r_idx0;
        r_idx2  <= r_idx1;
        r_mag_x <= ax[CB-1:0];
        r_mag_y <= ay[CB-1:0];
        r_sq_x  <= SQ_W'(r_mag_x) * SQ_W'(r_mag_x);
        r_sq_y  <= SQ_W'(r_mag_y) * SQ_W'(r_mag_y);
        if (r_v2 && better) begin
            r_best_dist <= dist_sat;
            r_best_idx  <= r_idx2;
        end
        if (i_ctl.load_out) begin
            r_out_idx   <= r_found ? best_idx_ext[nps_pkg::IDX_OUT_W-1:0] : r_res_idx;
            r_out_dist  <= r_found ? r_best_dist : '0;
            r_out_found <= r_found;
            r_out_full  <= r_res_full;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.scan_last  = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);
    assign o_stat.pipe_busy  = r_v0 || r_v1 || r_v2;
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    assign o_valid           = r_out_valid;
    assign o_nearest_index   = r_out_idx;
    assign o_nearest_dist_sq = r_out_dist;
    assign o_found           = r_out_found;
    assign o_table_full      = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above table size");

    a_scan_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> (CNT_W'(r_idx0) < r_count))
        else $error("scan read beyond stored points");

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |-> !(r_v0 || r_v1 || r_v2))
        else $error("result loaded while scan pipeline busy");

    a_found_compared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.load_out && r_found) |-> !r_first)
        else $error("query result without any compare");

endmodule

@@ rtl/core/nearest_point_search_top.sv @@
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_cmd, i_pos_x, i_pos_y
// result    out        o_valid / i_stall    o_nearest_index, o_nearest_dist_sq,
//                                           o_found, o_table_full
//
// clear and insert: no scan; the result goes into the output register once that register is free
// query: one stored point read per cycle from the single-port memory, then the difference,
// square and compare stages, a drain until the pipeline is empty, and the result load
// o_stall is low only while the controller is idle, from the cycle after each result load
// i_stall holds a waiting result in the output register; the next item runs up to its load
// i_rst_n (synchronous) empties the table; point memory contents are not cleared
module nearest_point_search_top #(
    parameter int MAX_POINTS = nps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [nps_pkg::POS_W-1:0]     i_pos_x,
    input  logic [nps_pkg::POS_W-1:0]     i_pos_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nps_pkg::IDX_OUT_W-1:0] o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]    o_nearest_dist_sq,
    output logic                          o_found,
    output logic                          o_table_full
);

    nps_pkg::t_dp_cmd  ctl;
    nps_pkg::t_dp_stat stat;

    nps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_cmd   (ctl),
        .o_stall (o_stall)
    );

    nps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (i_cmd),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_stall           (i_stall),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_dist_sq (o_nearest_dist_sq),
        .o_found           (o_found),
        .o_table_full      (o_table_full)
    );

endmodule

@@ test/nearest_point_search_top_tb.sv @@
module nearest_point_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = nps_pkg::DEF_MAX_POINTS;
    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 650;

    // expected result of one command and the shadow copy of the point table
    class nearest_point_predictor;
        typedef struct packed {
            logic [nps_pkg::IDX_OUT_W-1:0] index;
            logic [nps_pkg::DIST_W-1:0]    dist_sq;
            logic                          found;
            logic                          full;
        } t_answer;

        logic signed [nps_pkg::POS_W-1:0] table_x [TABLE_DEPTH];
        logic signed [nps_pkg::POS_W-1:0] table_y [TABLE_DEPTH];
        int unsigned             stored;
        t_answer                 pending_answers[$];
        int unsigned             mismatches;

        function void take_command(nps_pkg::t_cmd cmd, logic [nps_pkg::POS_W-1:0] x,
                                   logic [nps_pkg::POS_W-1:0] y);
            t_answer ans;
            longint  dx;
            longint  dy;
            longint  d;
            longint  best;
            ans  = '0;
            best = 0;
            case (cmd)
                nps_pkg::CMD_CLEAR: begin
                    stored = 0;
                end
                nps_pkg::CMD_INSERT: begin
                    if (stored < TABLE_DEPTH) begin
                        table_x[stored] = $signed(x);
                        table_y[stored] = $signed(y);
                        ans.index = nps_pkg::IDX_OUT_W'(stored);
                        stored++;
                    end else begin
                        ans.full = 1'b1;
                    end
                end
                nps_pkg::CMD_QUERY: begin
                    if (stored > 0) begin
                        ans.found = 1'b1;
                        for (int unsigned i = 0; i < stored; i++) begin
                            dx = longint'(table_x[i]) - longint'($signed(x));
                            dy = longint'(table_y[i]) - longint'($signed(y));
                            d  = dx * dx + dy * dy;
                            // strict less-than keeps the lowest index on ties
                            if (i == 0 || d < best) begin
                                best = d;
                                ans.index = nps_pkg::IDX_OUT_W'(i);
                            end
                        end
                        if (best > longint'(nps_pkg::DIST_MAX))
                            best = longint'(nps_pkg::DIST_MAX);
                        ans.dist_sq = nps_pkg::DIST_W'(best);
                    end
                end
                default: ;
            endcase
            pending_answers = {pending_answers, ans};
        endfunction

        function void check_answer(logic [nps_pkg::IDX_OUT_W-1:0] index,
                                   logic [nps_pkg::DIST_W-1:0] dist_sq,
                                   logic found, logic full);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            if (index !== want.index) begin
                $error("nearest_index: expected %0d, got %0d", want.index, index);
                mismatches++;
            end
            if (dist_sq !== want.dist_sq) begin
                $error("nearest_dist_sq: expected %0d, got %0d", want.dist_sq, dist_sq);
                mismatches++;
            end
            if (found !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, found);
                mismatches++;
            end
            if (full !== want.full) begin
                $error("table_full: expected %0b, got %0b", want.full, full);
                mismatches++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [1:0]                    i_cmd;
    logic [nps_pkg::POS_W-1:0]     i_pos_x;
    logic [nps_pkg::POS_W-1:0]     i_pos_y;
    logic                          o_valid;
    logic                          i_stall;
    logic [nps_pkg::IDX_OUT_W-1:0] o_nearest_index;
    logic [nps_pkg::DIST_W-1:0]    o_nearest_dist_sq;
    logic                          o_found;
    logic                          o_table_full;

    nearest_point_predictor predictor = new;
    int unsigned            items_sent;
    int unsigned            idle_cycles;
    bit                     send_burst;
    bit                     sink_burst;

    nearest_point_search_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_dist_sq (o_nearest_dist_sq),
        .o_found           (o_found),
        .o_table_full      (o_table_full)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before each transfer, with stretches of none
    initial begin
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 24) == 0)
                sink_burst = !sink_burst;
            hold = sink_burst ? 0 : $urandom_range(0, 19);
            @(negedge i_clk);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            predictor.check_answer(o_nearest_index, o_nearest_dist_sq, o_found, o_table_full);
        end
    end

    task automatic send_item(nps_pkg::t_cmd cmd, logic [nps_pkg::POS_W-1:0] x,
                             logic [nps_pkg::POS_W-1:0] y);
        int unsigned gap;
        if ($urandom_range(0, 24) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_pos_x <= x;
        i_pos_y <= y;
        do @(posedge i_clk); while (o_stall);
        predictor.take_command(cmd, x, y);
        items_sent++;
    endtask

    // drop valid and hold off until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predictor.pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [nps_pkg::POS_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            // tight cluster, many ties
            2, 3:    return nps_pkg::POS_W'($urandom_range(0, 15)) - 16'd8;
            default: return nps_pkg::POS_W'($urandom);
        endcase
    endfunction

    function automatic nps_pkg::t_cmd pick_cmd();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return nps_pkg::CMD_CLEAR;
        else if (roll < 22)
            return nps_pkg::CMD_INSERT;
        return nps_pkg::CMD_QUERY;
    endfunction

    task automatic run_directed();
        send_item(nps_pkg::CMD_QUERY,  16'h0000, 16'h0000);
        send_item(nps_pkg::CMD_QUERY,  16'h8000, 16'h7FFF);
        send_item(nps_pkg::CMD_INSERT, 16'h8000, 16'h8000);
        send_item(nps_pkg::CMD_QUERY,  16'h7FFF, 16'h7FFF);    // largest possible distance
        send_item(nps_pkg::CMD_INSERT, 16'h7FFF, 16'h7FFF);
        send_item(nps_pkg::CMD_QUERY,  16'h0000, 16'h0000);
        send_item(nps_pkg::CMD_INSERT, 16'h7FFF, 16'h7FFF);
        send_item(nps_pkg::CMD_QUERY,  16'h7FFF, 16'h7FFF);    // exact duplicate, lower index wins
        send_item(nps_pkg::CMD_INSERT, 16'hFFFF, 16'h0000);
        send_item(nps_pkg::CMD_INSERT, 16'h0000, 16'hFFFF);
        send_item(nps_pkg::CMD_QUERY,  16'h0000, 16'h0000);    // equal distance to two points
        send_item(nps_pkg::CMD_INSERT, 16'h5555, 16'hAAAA);
        send_item(nps_pkg::CMD_INSERT, 16'hAAAA, 16'h5555);
        send_item(nps_pkg::CMD_QUERY,  16'h5555, 16'hAAAA);
        send_item(nps_pkg::CMD_CLEAR,  16'hFFFF, 16'hFFFF);
        send_item(nps_pkg::CMD_QUERY,  16'h0001, 16'h0001);
        send_item(nps_pkg::CMD_INSERT, 16'h0100, 16'h0100);
        send_item(nps_pkg::CMD_QUERY,  16'h8000, 16'h8000);
        send_item(nps_pkg::CMD_CLEAR,  16'h0000, 16'h0000);
    endtask

    // fill the table to the brim, overflow it, then query the full table
    task automatic run_fill();
        send_item(nps_pkg::CMD_CLEAR, pick_coord(), pick_coord());
        repeat (TABLE_DEPTH + $urandom_range(1, 4))
            send_item(nps_pkg::CMD_INSERT, pick_coord(), pick_coord());
        repeat ($urandom_range(3, 6))
            send_item(nps_pkg::CMD_QUERY, pick_coord(), pick_coord());
    endtask

    task automatic run_session();
        if ($urandom_range(0, 3) == 0)
            send_item(nps_pkg::CMD_CLEAR, pick_coord(), pick_coord());
        repeat ($urandom_range(0, 10))
            send_item(nps_pkg::CMD_INSERT, pick_coord(), pick_coord());
        repeat ($urandom_range(1, 8))
            send_item(pick_cmd(), pick_coord(), pick_coord());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_cmd       = nps_pkg::CMD_CLEAR;
        i_pos_x     = '0;
        i_pos_y     = '0;
        items_sent  = 0;
        idle_cycles = 0;
        send_burst  = 1'b0;
        sink_burst  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_results();
        run_fill();
        drain_results();
        while (items_sent < ITEM_TARGET)
            run_session();

        drain_results();
        repeat (30) @(posedge i_clk);
        if (predictor.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
